@@ rtl/decimating_sensor_averager_core_macros.svh @@
// Assertion macros shared by the decimating sensor averager modules.
`ifndef DECIMATING_SENSOR_AVERAGER_CORE_MACROS_SVH
`define DECIMATING_SENSOR_AVERAGER_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define DSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/dsa_pkg.sv @@
// Shared widths, codes, types and helpers of the decimating sensor averager.
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = 20;
    localparam int PERIOD_W = 9;
    localparam int SUM_W    = VALUE_W + PERIOD_W;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W   = 8;

    localparam logic [MODE_W-1:0] MODE_HEART = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEMP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SKIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LAST = 2'd2;

    // Result and status of the serial divider.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quot;
    } t_div_res;

    // Clamps a running value to the largest output value.
    function automatic logic [VALUE_W-1:0] sat_value(input logic [SUM_W-1:0] v);
        logic [VALUE_W-1:0] r;
        r = (|v[SUM_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : v[VALUE_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/decimating_sensor_averager_core.sv @@
// A sample that does not end a period only updates the running sum and tick count.
// A period end in hold-last mode registers the saturated sum and then loads its
// conversion once the output is free. In average mode the bit-serial divider, which
// takes one quotient bit per cycle, runs first and its saturated quotient is converted.
// Sync active-low reset: period 1, mode 0, hold-last 1; clears all but the data regs.
`timescale 1ns / 1ps
`include "decimating_sensor_averager_core_macros.svh"

module decimating_sensor_averager_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dsa_pkg::PERIOD_W-1:0]        i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,   // [11:0] sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata    // [19:0] value
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_CONV = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [dsa_pkg::PERIOD_W-1:0]       r_period;
    logic [dsa_pkg::MODE_W-1:0]         r_mode;
    logic                               r_hold;
    logic [dsa_pkg::PERIOD_W-1:0]       r_tick, n_tick;
    logic [dsa_pkg::SUM_W-1:0]          r_rs, n_rs;
    logic [dsa_pkg::VALUE_W-1:0]        r_last, n_last;
    logic [dsa_pkg::VALUE_W-1:0]        r_x, n_x;
    logic                               r_out_valid, n_out_valid;
    logic [dsa_pkg::VALUE_W-1:0]        r_out_data, n_out_data;

    logic                               w_acc;
    logic                               w_end;
    logic                               w_start;
    logic [dsa_pkg::PERIOD_W-1:0]       w_eff;
    logic [dsa_pkg::PERIOD_W-1:0]       w_tick_inc;
    logic [dsa_pkg::SAMPLE_W-1:0]       w_sample;
    logic [dsa_pkg::SUM_W-1:0]          w_s8;
    logic [dsa_pkg::SUM_W-1:0]          w_rs_upd;
    logic [dsa_pkg::VALUE_W-1:0]        w_conv;
    dsa_pkg::t_div_res                  w_div;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= dsa_pkg::PERIOD_W'(1);
            r_mode   <= dsa_pkg::MODE_HEART;
            r_hold   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dsa_pkg::CFG_PERIOD:    r_period <= i_cfg_data;
                dsa_pkg::CFG_MODE:      r_mode   <= i_cfg_data[dsa_pkg::MODE_W-1:0];
                dsa_pkg::CFG_HOLD_LAST: r_hold   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff      = (r_period == '0) ? dsa_pkg::PERIOD_W'(1) : r_period;
        w_tick_inc = r_tick + 1'b1;
        w_sample   = s_axis_tdata[dsa_pkg::SAMPLE_W-1:0];
        w_s8       = dsa_pkg::SUM_W'({w_sample, {dsa_pkg::FRAC_W{1'b0}}});
        // A zero sample means no reading and brings back the last output.
        if (w_sample != '0) begin
            w_rs_upd = r_hold ? w_s8 : (r_rs + w_s8);
        end else begin
            w_rs_upd = dsa_pkg::SUM_W'(r_last);
        end
        w_end   = (w_tick_inc >= w_eff);
        w_start = w_acc && w_end && !r_hold;
    end

    dsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_rs_upd),
        .i_divisor  (w_eff),
        .o_res      (w_div)
    );

    dsa_conv u_conv (
        .i_mode  (r_mode),
        .i_x     (r_x),
        .o_value (w_conv)
    );

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_rs        = r_rs;
        n_last      = r_last;
        n_x         = r_x;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (w_end) begin
                        n_tick = '0;
                        n_rs   = '0;
                        if (r_hold) begin
                            n_x     = dsa_pkg::sat_value(w_rs_upd);
                            n_state = ST_CONV;
                        end else begin
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_tick = w_tick_inc;
                        n_rs   = w_rs_upd;
                    end
                end
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_x     = dsa_pkg::sat_value(w_div.quot);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // Waits for the output register to be free before loading.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_conv;
                    n_last      = w_conv;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tick      <= '0;
            r_rs        <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_rs        <= n_rs;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_out_data <= n_out_data;
    end

    `DSA_ASSERT(a_div_launch, w_start |=> (w_div.busy && r_state == ST_DIV), "divider not launched")
    `DSA_ASSERT(a_done_in_div, w_div.done |-> (r_state == ST_DIV), "divider result outside divide state")
    `DSA_ASSERT(a_cleared_busy, (r_state != ST_IDLE) |-> (r_tick == '0 && r_rs == '0), "period state not cleared")

endmodule

@@ rtl/dsa_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`include "decimating_sensor_averager_core_macros.svh"

module dsa_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [dsa_pkg::SUM_W-1:0]       i_dividend,
    input  logic [dsa_pkg::PERIOD_W-1:0]    i_divisor,
    output dsa_pkg::t_div_res               o_res
);

    localparam int CNT_W = $clog2(dsa_pkg::SUM_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(dsa_pkg::SUM_W - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [dsa_pkg::PERIOD_W-1:0]   r_rem;
    logic [dsa_pkg::PERIOD_W-1:0]   r_div;
    logic [dsa_pkg::SUM_W-1:0]      r_quo;

    logic [dsa_pkg::PERIOD_W:0]     w_trial;
    logic [dsa_pkg::PERIOD_W:0]     w_diff;
    logic                           w_qbit;

    // The dividend shifts out of the top of r_quo as quotient bits shift in below.
    always_comb begin
        w_trial = {r_rem, r_quo[dsa_pkg::SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_qbit  = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_qbit ? w_diff[dsa_pkg::PERIOD_W-1:0] : w_trial[dsa_pkg::PERIOD_W-1:0];
            r_quo <= {r_quo[dsa_pkg::SUM_W-2:0], w_qbit};
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.quot = r_quo;

    `DSA_ASSERT(a_no_restart, !(i_start && r_busy), "divider started while busy")
    `DSA_ASSERT(a_done_idle, r_done |-> !r_busy, "divider done while still busy")
    `DSA_ASSERT(a_rem_bound, r_busy |-> (r_rem < r_div), "remainder not below divisor")

endmodule

@@ rtl/dsa_conv.sv @@
// Per-mode conversion of an averaged or held Q.8 value.
`timescale 1ns / 1ps

module dsa_conv (
    input  logic [dsa_pkg::MODE_W-1:0]   i_mode,
    input  logic [dsa_pkg::VALUE_W-1:0]  i_x,
    output logic [dsa_pkg::VALUE_W-1:0]  o_value
);

    localparam int PROD_W = dsa_pkg::VALUE_W + 10;
    localparam logic [dsa_pkg::VALUE_W-1:0] HR_MIN  = dsa_pkg::VALUE_W'(30 << dsa_pkg::FRAC_W);
    localparam logic [dsa_pkg::VALUE_W-1:0] T_BASE  = dsa_pkg::VALUE_W'(65 << dsa_pkg::FRAC_W);
    localparam logic [dsa_pkg::VALUE_W-1:0] T_MAX   = dsa_pkg::VALUE_W'(105 << dsa_pkg::FRAC_W);
    localparam logic [dsa_pkg::VALUE_W-1:0] SC_FULL = dsa_pkg::VALUE_W'(1000 << dsa_pkg::FRAC_W);

    logic [PROD_W-1:0]           w_x;
    logic [PROD_W-1:0]           w_p30;
    logic [PROD_W-1:0]           w_p1000;
    logic [dsa_pkg::VALUE_W-1:0] w_temp;
    logic [PROD_W-1:0]           w_skin_t;

    // Scaling by 30 and by 1000 is done with shifts and subtracts;
    // dividing by 4096 is a right shift by twelve.
    always_comb begin
        w_x      = PROD_W'(i_x);
        w_p30    = (w_x << 5) - (w_x << 1);
        w_p1000  = (w_x << 10) - (w_x << 4) - (w_x << 3);
        w_temp   = dsa_pkg::VALUE_W'(w_p30 >> 12) + T_BASE;
        w_skin_t = w_p1000 >> 12;
        case (i_mode)
            dsa_pkg::MODE_HEART: o_value = (i_x < HR_MIN) ? HR_MIN : i_x;
            dsa_pkg::MODE_TEMP:  o_value = (w_temp > T_MAX) ? T_MAX : w_temp;
            dsa_pkg::MODE_SKIN: begin
                if (w_skin_t >= PROD_W'(SC_FULL)) begin
                    o_value = '0;
                end else begin
                    o_value = SC_FULL - w_skin_t[dsa_pkg::VALUE_W-1:0];
                end
            end
            default: o_value = i_x;
        endcase
    end

endmodule

@@ tb/sv/decimating_sensor_averager_core_test.sv @@
// Self-checking testbench for the decimating sensor averager core, compared against a local predictor.
`timescale 1ns / 1ps

module decimating_sensor_averager_core_test;
    import dsa_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_RAW  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [63:0] HEART_FLOOR = 64'd30 << FRAC_W;
    localparam logic [63:0] TEMP_LO     = 64'd65 << FRAC_W;
    localparam logic [63:0] TEMP_HI     = 64'd105 << FRAC_W;
    localparam logic [63:0] SKIN_TOP    = 64'd1000 << FRAC_W;

    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE_LIMIT = 20000;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_OFF     = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PERIOD_W-1:0]  i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [11:0] sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;   // [19:0] value

    decimating_sensor_averager_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the registers and state, at their reset values.
    logic [PERIOD_W-1:0] period_cfg = 9'd1;
    logic [MODE_W-1:0]   mode_cfg   = MODE_HEART;
    logic                hold_cfg   = 1'b1;
    logic [PERIOD_W-1:0] tick_q     = '0;
    logic [SUM_W-1:0]    sum_q      = '0;
    logic [VALUE_W-1:0]  last_q     = '0;

    logic [VALUE_W-1:0] pending_values[$];

    int  err_count      = 0;
    int  samples_sent   = 0;
    int  values_checked = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    int  stall_len      = 0;
    int  stall_req_id   = 0;
    int  stall_ack_id   = 0;
    int  stall_left     = 0;

    function automatic logic [VALUE_W-1:0] convert_q8(input logic [MODE_W-1:0] m,
                                                      input logic [VALUE_W-1:0] x);
        logic [63:0] wide;
        logic [63:0] r;
        logic [63:0] t;
        wide = 64'(x);
        case (m)
            MODE_HEART: r = (wide < HEART_FLOOR) ? HEART_FLOOR : wide;
            MODE_TEMP: begin
                r = wide * 30 / 4096 + TEMP_LO;
                if (r > TEMP_HI) r = TEMP_HI;
            end
            MODE_SKIN: begin
                t = wide * 1000 / 4096;
                r = (t >= SKIN_TOP) ? 64'd0 : SKIN_TOP - t;
            end
            default: r = wide;
        endcase
        return r[VALUE_W-1:0];
    endfunction

    // Advances the boxcar state by one accepted sample and queues the value it emits.
    function automatic void boxcar_step(input logic [SAMPLE_W-1:0] smp);
        logic [PERIOD_W-1:0] eff;
        logic [SUM_W-1:0]    x;
        logic [VALUE_W-1:0]  sat;
        eff = (period_cfg == '0) ? 9'd1 : period_cfg;
        tick_q = tick_q + 9'd1;
        if (smp != '0) begin
            if (hold_cfg) sum_q = SUM_W'({smp, 8'h00});
            else sum_q = sum_q + SUM_W'({smp, 8'h00});
        end else begin
            sum_q = SUM_W'(last_q);
        end
        if (tick_q < eff) return;
        x = hold_cfg ? sum_q : sum_q / SUM_W'(eff);
        sat = (x > SUM_W'({VALUE_W{1'b1}})) ? {VALUE_W{1'b1}} : x[VALUE_W-1:0];
        last_q = convert_q8(mode_cfg, sat);
        sum_q = '0;
        tick_q = '0;
        pending_values.push_back(last_q);
    endfunction

    function automatic void note_failure(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 12) return '0;
        if (r < 17) return 12'hFFF;
        if (r < 20) return 12'h001;
        return SAMPLE_W'($urandom_range(4095, 1));
    endfunction

    // Output side: random ready, the requested hold-off, and the value check.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                note_failure($sformatf("unexpected value %0d", m_axis_tdata[VALUE_W-1:0]));
            end else begin
                if (m_axis_tdata[VALUE_W-1:0] !== pending_values[0])
                    note_failure($sformatf("value mismatch: expected %0d, got %0d",
                                           pending_values[0], m_axis_tdata[VALUE_W-1:0]));
                void'(pending_values.pop_front());
                values_checked++;
            end
        end
        if (stall_req_id != stall_ack_id) begin
            stall_ack_id = stall_req_id;
            stall_left = stall_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= rx_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        if (tx_idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        boxcar_step(smp);
        samples_sent++;
    endtask

    // Stops the input and lets every outstanding value and any divide finish.
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Valid stays high when another write follows in the next request.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data,
                             input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_PERIOD:    period_cfg = data;
            CFG_MODE:      mode_cfg = data[MODE_W-1:0];
            CFG_HOLD_LAST: hold_cfg = data[0];
            default: ;
        endcase
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [PERIOD_W-1:0] per, input logic [MODE_W-1:0] m,
                              input logic hold);
        settle();
        write_cfg(CFG_PERIOD, per, 1'b1);
        write_cfg(CFG_MODE, PERIOD_W'(m), 1'b1);
        write_cfg(CFG_HOLD_LAST, PERIOD_W'(hold), 1'b0);
    endtask

    task automatic test_defaults();
        send_sample(12'h000);
        send_sample(12'h001);
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hAAA);
        send_sample(12'h555);
        // The unused register index must leave the behavior alone.
        settle();
        write_cfg(CFG_SPARE, 9'h1FF, 1'b0);
        send_sample(12'h800);
    endtask

    task automatic test_each_mode();
        logic [MODE_W-1:0] m;
        for (int i = 0; i < 4; i++) begin
            m = MODE_W'(i);
            set_config(9'd1, m, 1'b1);
            send_sample(12'hFFF);
            send_sample(12'h001);
            send_sample(12'h000);
        end
    endtask

    task automatic test_average_edges();
        set_config(9'd3, MODE_HEART, 1'b0);
        repeat (3) send_sample(12'hFFF);
        // A period of zero behaves as a period of one.
        set_config(9'd0, MODE_TEMP, 1'b0);
        send_sample(12'h800);
        set_config(9'd2, MODE_SKIN, 1'b0);
        send_sample(12'h000);
        send_sample(12'hFFF);
    endtask

    // Lowering the period mid-run ends it at once, and the oversized average saturates.
    task automatic test_period_cut();
        set_config(9'd300, MODE_RAW, 1'b0);
        repeat (200) send_sample(12'hFFF);
        set_config(9'd1, MODE_RAW, 1'b0);
        send_sample(12'hFFF);
    endtask

    task automatic test_long_periods();
        set_config(9'd256, MODE_SKIN, 1'b0);
        repeat (256) send_sample(12'hFFF);
        set_config(9'd511, MODE_TEMP, 1'b0);
        repeat (511) send_sample(pick_sample());
    endtask

    task automatic test_output_backpressure();
        set_config(9'd1, MODE_RAW, 1'b1);
        stall_len = HOLD_OFF;
        stall_req_id++;
        tx_idle_on = 1'b0;
        repeat (40) send_sample(pick_sample());
        tx_idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        set_config(9'd2, MODE_TEMP, 1'b0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (160) send_sample(pick_sample());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_phases(input int budget);
        int sent;
        int n;
        int r;
        int eff;
        logic [PERIOD_W-1:0] per;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 10) per = '0;
            else if (r < 75) per = PERIOD_W'($urandom_range(8, 1));
            else if (r < 95) per = PERIOD_W'($urandom_range(40, 9));
            else per = PERIOD_W'($urandom_range(100, 41));
            set_config(per, MODE_W'($urandom_range(3)), 1'($urandom_range(1)));
            eff = (per == '0) ? 1 : int'(per);
            n = eff * $urandom_range(4, 1);
            // Sometimes leave a period partly filled for the next setting.
            if ($urandom_range(3) == 0) n += $urandom_range(eff - 1);
            repeat (n) send_sample(pick_sample());
            sent += n;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_PERIOD;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_each_mode();
        test_average_edges();
        test_period_cut();
        test_long_periods();
        test_output_backpressure();
        test_back_to_back();
        test_random_phases(540);

        settle();
        if (pending_values.size() != 0)
            note_failure($sformatf("%0d values never arrived", pending_values.size()));
        $display("Sent %0d samples and checked %0d values over all four conversion modes,",
                 samples_sent, values_checked);
        $display("hold-last and averaging, periods 0 to 511 and a %0d-cycle output hold-off.",
                 HOLD_OFF);
        if (err_count == 0) begin
            $display("decimating_sensor_averager_core regression: pass");
        end else begin
            $display("%0d failures", err_count);
            $display("decimating_sensor_averager_core regression: fail");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timed out with %0d values outstanding", pending_values.size());
        $display("decimating_sensor_averager_core regression: fail");
        $finish;
    end

endmodule
